// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions of the JSON string
// unescaper: parse modes, job records and UTF-8 encoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [3:0] {
    MODE_QUOTE   = 4'd0,
    MODE_SKIP    = 4'd1,
    MODE_BODY    = 4'd2,
    MODE_ESC     = 4'd3,
    MODE_HEX     = 4'd4,
    MODE_HIGH    = 4'd5,
    MODE_HIGH_BS = 4'd6,
    MODE_LOW     = 4'd7,
    MODE_LOW_BAD = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    BK_NONE = 2'd0,
    BK_RAW  = 2'd1,
    BK_CP   = 2'd2
  } bkind_e;

  typedef enum logic [1:0] {
    TRL_NONE = 2'd0,
    TRL_DONE = 2'd1,
    TRL_ERR  = 2'd2
  } trail_e;

  typedef enum logic [1:0] {
    ESC_LIT = 2'd0,
    ESC_UNI = 2'd1,
    ESC_BAD = 2'd2
  } esc_e;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
  localparam logic [2:0] ERR_UNTERM    = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
  localparam logic [2:0] ERR_BAD_LOW   = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // one unit of work handed from the parser to the output sequencer
  typedef struct packed {
    logic          a_vld;   // flush of a held high surrogate
    logic [15:0]   a_cp;
    bkind_e        b_kind;
    logic [20:0]   b_val;
    trail_e        trl;
    logic [2:0]    err_code;
  } job_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    esc_e       kind;
    logic [7:0] chr;
  } esc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.n    = 3'd1;
      e.b[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7FF) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.kind = ESC_LIT;
    r.chr  = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.chr = c;
      CH_B: r.chr = 8'h08;
      CH_F: r.chr = 8'h0C;
      CH_N: r.chr = 8'h0A;
      CH_R: r.chr = 8'h0D;
      CH_T: r.chr = 8'h09;
      CH_U: r.kind = ESC_UNI;
      default: r.kind = ESC_BAD;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: takes one input word per cycle unless the queue is full, tracks the
// escape state and turns words with output into job records for the sequencer.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    ch_i,
  input  logic          end_of_line_i,
  input  logic          full_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  logic [15:0]    held_q, held_d;

  logic           accept;
  jsu_pkg::hex_t  hv;
  jsu_pkg::esc_t  em;
  logic [15:0]    acc_sh, acc_n;
  logic [2:0]     cnt_inc;
  logic           bad;
  logic           err;
  logic [2:0]     err_code;
  logic           done;
  jsu_pkg::job_t  job;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  always_comb begin
    hv       = jsu_pkg::hex_val(ch_i);
    em       = jsu_pkg::esc_map(ch_i);
    acc_sh   = {acc_q[11:0], hv.val};
    acc_n    = hv.ok ? acc_sh : acc_q;
    cnt_inc  = cnt_q + 3'd1;
    bad      = 1'b0;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    held_d   = held_q;
    err      = 1'b0;
    err_code = jsu_pkg::ERR_NO_QUOTE;
    done     = 1'b0;
    job      = '0;
    job.a_cp = held_q;

    case (mode_q)
      jsu_pkg::MODE_QUOTE: begin
        if (ch_i == jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_BODY;
        end else begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_NO_QUOTE;
        end
      end
      jsu_pkg::MODE_BODY, jsu_pkg::MODE_HIGH: begin
        if (mode_q == jsu_pkg::MODE_HIGH && ch_i == jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_HIGH_BS;
        end else begin
          job.a_vld = (mode_q == jsu_pkg::MODE_HIGH);
          mode_d    = jsu_pkg::MODE_BODY;
          if (ch_i == jsu_pkg::CH_QUOTE) begin
            done = 1'b1;
          end else if (ch_i == jsu_pkg::CH_BSLASH) begin
            mode_d = jsu_pkg::MODE_ESC;
          end else begin
            job.b_kind = jsu_pkg::BK_RAW;
            job.b_val  = {13'd0, ch_i};
          end
        end
      end
      jsu_pkg::MODE_ESC, jsu_pkg::MODE_HIGH_BS: begin
        if (mode_q == jsu_pkg::MODE_HIGH_BS && ch_i == jsu_pkg::CH_U) begin
          mode_d = jsu_pkg::MODE_LOW;
          cnt_d  = '0;
          acc_d  = '0;
        end else begin
          job.a_vld = (mode_q == jsu_pkg::MODE_HIGH_BS);
          case (em.kind)
            jsu_pkg::ESC_LIT: begin
              job.b_kind = jsu_pkg::BK_RAW;
              job.b_val  = {13'd0, em.chr};
              mode_d     = jsu_pkg::MODE_BODY;
            end
            jsu_pkg::ESC_UNI: begin
              mode_d = jsu_pkg::MODE_HEX;
              cnt_d  = '0;
              acc_d  = '0;
            end
            default: begin
              mode_d   = jsu_pkg::MODE_ESC;
              err      = 1'b1;
              err_code = jsu_pkg::ERR_BAD_ESC;
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hv.ok) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_BAD_HEX;
        end else begin
          acc_d = acc_sh;
          cnt_d = cnt_inc;
          if (cnt_inc[2]) begin
            if (acc_sh >= jsu_pkg::HIGH_MIN && acc_sh <= jsu_pkg::HIGH_MAX) begin
              held_d = acc_sh;
              mode_d = jsu_pkg::MODE_HIGH;
            end else begin
              job.b_kind = jsu_pkg::BK_CP;
              job.b_val  = {5'd0, acc_sh};
              mode_d     = jsu_pkg::MODE_BODY;
            end
          end
        end
      end
      jsu_pkg::MODE_LOW, jsu_pkg::MODE_LOW_BAD: begin
        bad    = (mode_q == jsu_pkg::MODE_LOW_BAD) | ~hv.ok;
        mode_d = bad ? jsu_pkg::MODE_LOW_BAD : mode_q;
        acc_d  = acc_n;
        cnt_d  = cnt_inc;
        if (cnt_inc[2]) begin
          if (bad) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_BAD_LOW;
          end else if (acc_n >= jsu_pkg::LOW_MIN && acc_n <= jsu_pkg::LOW_MAX) begin
            job.b_kind = jsu_pkg::BK_CP;
            job.b_val  = jsu_pkg::SUPP_BASE + {1'b0, held_q[9:0], acc_n[9:0]};
            mode_d     = jsu_pkg::MODE_BODY;
          end else begin
            job.a_vld = 1'b1;
            if (acc_n >= jsu_pkg::HIGH_MIN && acc_n <= jsu_pkg::HIGH_MAX) begin
              held_d = acc_n;
              mode_d = jsu_pkg::MODE_HIGH;
            end else begin
              job.b_kind = jsu_pkg::BK_CP;
              job.b_val  = {5'd0, acc_n};
              mode_d     = jsu_pkg::MODE_BODY;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      job.a_vld    = 1'b0;
      job.b_kind   = jsu_pkg::BK_NONE;
      job.trl      = jsu_pkg::TRL_ERR;
      job.err_code = err_code;
      mode_d       = end_of_line_i ? jsu_pkg::MODE_QUOTE : jsu_pkg::MODE_SKIP;
    end else if (done) begin
      job.trl = jsu_pkg::TRL_DONE;
      mode_d  = end_of_line_i ? jsu_pkg::MODE_QUOTE : jsu_pkg::MODE_SKIP;
    end else if (end_of_line_i) begin
      if (mode_d != jsu_pkg::MODE_QUOTE && mode_d != jsu_pkg::MODE_SKIP) begin
        job.a_vld  = 1'b0;
        job.b_kind = jsu_pkg::BK_NONE;
        job.trl    = jsu_pkg::TRL_ERR;
        if (mode_d == jsu_pkg::MODE_HEX || mode_d == jsu_pkg::MODE_LOW ||
            mode_d == jsu_pkg::MODE_LOW_BAD) begin
          job.err_code = jsu_pkg::ERR_BAD_HEX;
        end else begin
          job.err_code = jsu_pkg::ERR_UNTERM;
        end
      end
      mode_d = jsu_pkg::MODE_QUOTE;
    end
  end

  assign job_o  = job;
  assign push_o = accept &
                  (job.a_vld | (job.b_kind != jsu_pkg::BK_NONE) |
                   (job.trl != jsu_pkg::TRL_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_QUOTE;
      cnt_q  <= '0;
      acc_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

endmodule

// File: rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of job records between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_vld_o,
  output jsu_pkg::job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::job_t       entries_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = entries_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: expands the head job into UTF-8 bytes and any trailing
// done or error word into a registered output, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_vld_i,
  input  jsu_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    kind_o,
  output logic [2:0]    error_code_o,
  output logic          last_o
);

  jsu_pkg::enc_t  enc_a, enc_b;
  logic [2:0]     n_a, n_bytes, total;
  logic [2:0]     jj;
  logic [7:0]     bytes [6];
  logic [2:0]     idx_q, idx_d;
  logic           load;
  logic           at_end;

  logic           out_valid_q;
  logic [7:0]     out_byte_q, out_byte_d;
  logic [1:0]     kind_q, kind_d;
  logic [2:0]     code_q, code_d;
  logic           last_q;

  always_comb begin
    jj    = '0;
    enc_a = jsu_pkg::utf8_enc({5'd0, head_i.a_cp});
    case (head_i.b_kind)
      jsu_pkg::BK_RAW: begin
        enc_b      = '0;
        enc_b.n    = 3'd1;
        enc_b.b[0] = head_i.b_val[7:0];
      end
      jsu_pkg::BK_CP: enc_b = jsu_pkg::utf8_enc(head_i.b_val);
      default: enc_b = '0;
    endcase
    n_a     = head_i.a_vld ? enc_a.n : 3'd0;
    n_bytes = n_a + enc_b.n;
    total   = n_bytes + {2'd0, head_i.trl != jsu_pkg::TRL_NONE};
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < n_a) begin
        bytes[i] = enc_a.b[2'(i)];
      end else begin
        jj       = 3'(i) - n_a;
        bytes[i] = enc_b.b[jj[1:0]];
      end
    end
  end

  assign load   = head_vld_i & (~out_valid_q | ~out_stall_i);
  assign at_end = (idx_q == total - 3'd1);
  assign pop_o  = load & at_end;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
    if (idx_q < n_bytes) begin
      out_byte_d = bytes[idx_q];
      kind_d     = jsu_pkg::KIND_BYTE;
      code_d     = '0;
    end else if (head_i.trl == jsu_pkg::TRL_ERR) begin
      out_byte_d = '0;
      kind_d     = jsu_pkg::KIND_ERR;
      code_d     = head_i.err_code;
    end else begin
      out_byte_d = '0;
      kind_d     = jsu_pkg::KIND_DONE;
      code_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
      kind_q     <= kind_d;
      code_q     <= code_d;
      last_q     <= at_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign kind_o       = kind_q;
  assign error_code_o = code_q;
  assign last_o       = last_q;

endmodule

// File: rtl/core/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Decodes a JSON string literal, one byte per word, into UTF-8 bytes with
// done and error words.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | ch_i, end_of_line_i
//   out     | output    | out_valid_o/out_stall_i | out_byte_o, kind_o,
//           |           |                        | error_code_o, last_o
//
// The parser takes one input word per cycle while the job queue has room.
// The sequencer emits an input word's results one after another, stalling
// with the output, so a word that yields several results holds it until all
// are out; QueueDepth jobs buffer it. Input words that yield no result never
// enter the queue. Results are registered in the output register once their
// job reaches the queue head. Reset returns the parser to awaiting the
// opening quote and empties the queue and output register.
// ----------------------------------------------------------------------------
module json_string_unescaper_core #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_vld;
  jsu_pkg::job_t job;
  jsu_pkg::job_t head;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .full_o     (full),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (head_vld),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of json_string_unescaper_core. A short directed table, then random
// lines of string literals with plain bytes, escapes, surrogate pairs and
// broken input. Every accepted word is run through a behavioral decoder, and
// its results, or a typed directed row's expected word, are checked in order
// against the output channel while both sides pause and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_WORDS   = 180;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_RESULTS    = 6;

  localparam logic [2:0] NO_ERR = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] c;
    logic       e;
    logic       typed;
    logic [1:0] kind;
    logic [2:0] code;
  } row_t;

  localparam row_t DIRECTED [27] = '{
    '{8'h78,              1'b0, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_NO_QUOTE},
    '{8'h79,              1'b1, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h00,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'hFF,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h44,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h38,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h33,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h64,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h44,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h45,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h30,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h30,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::KIND_DONE, NO_ERR},
    '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h71,              1'b1, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_BAD_ESC},
    '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h61,              1'b1, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_UNTERM},
    '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR},
    '{8'h67,              1'b1, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_BAD_HEX}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] ch        = 8'h00;
  logic       eol       = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  // decoder state
  jsu_pkg::mode_e pmode = jsu_pkg::MODE_QUOTE;
  logic [2:0]     ndig  = 3'd0;
  logic [15:0]    accum = 16'h0000;
  logic [15:0]    held  = 16'h0000;
  bit             step_done;
  word_t          step_res[$];

  word_t       pending_out[$];
  logic [7:0]  line_q[$];
  int          pace = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;

  json_string_unescaper_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .ch_i         (ch),
    .end_of_line_i(eol),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .kind_o       (kind),
    .error_code_o (error_code),
    .last_o       (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- behavioral decoder ----

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic put_res(input logic [7:0] d, input logic [1:0] k, input logic [2:0] cd);
    word_t w;
    w = '{d, k, cd, 1'b0};
    if (step_res.size() < MAX_RESULTS) step_res = {step_res, w};
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_res(cp[7:0], jsu_pkg::KIND_BYTE, NO_ERR);
    end else if (cp <= 21'h7FF) begin
      put_res({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, NO_ERR);
    end else if (cp <= 21'hFFFF) begin
      put_res({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, NO_ERR);
    end else begin
      put_res({5'b11110, cp[20:18]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[17:12]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, NO_ERR);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, NO_ERR);
    end
  endtask

  task automatic close_unicode(input logic [15:0] v);
    if (v >= jsu_pkg::HIGH_MIN && v <= jsu_pkg::HIGH_MAX) begin
      held  = v;
      pmode = jsu_pkg::MODE_HIGH;
    end else begin
      emit_utf8({5'd0, v});
      pmode = jsu_pkg::MODE_BODY;
    end
  endtask

  task automatic body_byte(input logic [7:0] c);
    if (c == jsu_pkg::CH_QUOTE) begin
      step_done = 1'b1;
    end else if (c == jsu_pkg::CH_BSLASH) begin
      pmode = jsu_pkg::MODE_ESC;
    end else begin
      put_res(c, jsu_pkg::KIND_BYTE, NO_ERR);
      pmode = jsu_pkg::MODE_BODY;
    end
  endtask

  task automatic esc_byte(input logic [7:0] c, output int err);
    logic [7:0] m;
    logic       hit;
    err = -1;
    hit = 1'b1;
    m   = c;
    case (c)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: m = c;
      jsu_pkg::CH_B: m = 8'h08;
      jsu_pkg::CH_F: m = 8'h0C;
      jsu_pkg::CH_N: m = 8'h0A;
      jsu_pkg::CH_R: m = 8'h0D;
      jsu_pkg::CH_T: m = 8'h09;
      jsu_pkg::CH_U: begin
        pmode = jsu_pkg::MODE_HEX;
        ndig  = 3'd0;
        accum = 16'h0000;
        hit   = 1'b0;
      end
      default: begin
        err = int'(jsu_pkg::ERR_BAD_ESC);
        hit = 1'b0;
      end
    endcase
    if (hit) begin
      put_res(m, jsu_pkg::KIND_BYTE, NO_ERR);
      pmode = jsu_pkg::MODE_BODY;
    end
  endtask

  task automatic unescape_word(input logic [7:0] c, input logic e);
    int          err;
    int          d;
    logic [20:0] cp;
    err = -1;
    step_res.delete();
    step_done = 1'b0;
    case (pmode)
      jsu_pkg::MODE_QUOTE: begin
        if (c == jsu_pkg::CH_QUOTE) pmode = jsu_pkg::MODE_BODY;
        else err = int'(jsu_pkg::ERR_NO_QUOTE);
      end
      jsu_pkg::MODE_BODY: body_byte(c);
      jsu_pkg::MODE_ESC: esc_byte(c, err);
      jsu_pkg::MODE_HEX: begin
        d = nibble_of(c);
        if (d < 0) begin
          err = int'(jsu_pkg::ERR_BAD_HEX);
        end else begin
          accum = {accum[11:0], d[3:0]};
          ndig  = ndig + 3'd1;
          if (ndig >= 3'd4) close_unicode(accum);
        end
      end
      jsu_pkg::MODE_HIGH: begin
        if (c == jsu_pkg::CH_BSLASH) begin
          pmode = jsu_pkg::MODE_HIGH_BS;
        end else begin
          emit_utf8({5'd0, held});
          pmode = jsu_pkg::MODE_BODY;
          body_byte(c);
        end
      end
      jsu_pkg::MODE_HIGH_BS: begin
        if (c == jsu_pkg::CH_U) begin
          pmode = jsu_pkg::MODE_LOW;
          ndig  = 3'd0;
          accum = 16'h0000;
        end else begin
          emit_utf8({5'd0, held});
          pmode = jsu_pkg::MODE_ESC;
          esc_byte(c, err);
        end
      end
      jsu_pkg::MODE_LOW, jsu_pkg::MODE_LOW_BAD: begin
        d = nibble_of(c);
        if (d < 0) pmode = jsu_pkg::MODE_LOW_BAD;
        else accum = {accum[11:0], d[3:0]};
        ndig = ndig + 3'd1;
        if (ndig >= 3'd4) begin
          if (pmode == jsu_pkg::MODE_LOW_BAD) begin
            err = int'(jsu_pkg::ERR_BAD_LOW);
          end else if (accum >= jsu_pkg::LOW_MIN && accum <= jsu_pkg::LOW_MAX) begin
            cp = jsu_pkg::SUPP_BASE + ((21'(held - jsu_pkg::HIGH_MIN) << 10) |
                                       21'(accum - jsu_pkg::LOW_MIN));
            emit_utf8(cp);
            pmode = jsu_pkg::MODE_BODY;
          end else begin
            emit_utf8({5'd0, held});
            close_unicode(accum);
          end
        end
      end
      default: ;
    endcase

    if (err >= 0) begin
      step_res.delete();
      put_res(8'h00, jsu_pkg::KIND_ERR, err[2:0]);
      pmode = e ? jsu_pkg::MODE_QUOTE : jsu_pkg::MODE_SKIP;
    end else if (step_done) begin
      put_res(8'h00, jsu_pkg::KIND_DONE, NO_ERR);
      pmode = e ? jsu_pkg::MODE_QUOTE : jsu_pkg::MODE_SKIP;
    end else if (e) begin
      if (pmode != jsu_pkg::MODE_QUOTE && pmode != jsu_pkg::MODE_SKIP) begin
        step_res.delete();
        put_res(8'h00, jsu_pkg::KIND_ERR,
                (pmode == jsu_pkg::MODE_HEX || pmode == jsu_pkg::MODE_LOW ||
                 pmode == jsu_pkg::MODE_LOW_BAD) ?
                jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_UNTERM);
      end
      pmode = jsu_pkg::MODE_QUOTE;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endtask

  // ---- line generation ----

  function automatic int pick_pause();
    int r;
    if (pace == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    c = 8'($urandom);
    if (nibble_of(c) >= 0) c = 8'h7A;
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] c);
    line_q = {line_q, c};
  endtask

  task automatic add_uesc(input logic [15:0] v);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endtask

  task automatic add_token();
    int          r;
    int          k;
    logic [7:0]  c;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      c = 8'($urandom);
      if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH) c = c ^ 8'h01;
      add_byte(c);
    end else if (r < 55) begin
      add_byte(jsu_pkg::CH_BSLASH);
      add_byte(simple_escape());
    end else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range('h0, 'h7F));
        1: v = 16'($urandom_range('h80, 'h7FF));
        2: v = 16'($urandom_range('h800, 'hD7FF));
        default: v = 16'($urandom_range('hDC00, 'hFFFF));
      endcase
      add_uesc(v);
    end else if (r < 85) begin
      add_uesc(16'($urandom_range('hD800, 'hDBFF)));
      add_uesc(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (r < 92) begin
      // lone high surrogate, unless the next token is a low surrogate escape
      add_uesc(16'($urandom_range('hD800, 'hDBFF)));
    end else if (r < 96) begin
      c = 8'($urandom);
      if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH || c == jsu_pkg::CH_SLASH ||
          c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
          c == jsu_pkg::CH_R || c == jsu_pkg::CH_T || c == jsu_pkg::CH_U) c = 8'h78;
      add_byte(jsu_pkg::CH_BSLASH);
      add_byte(c);
    end else begin
      if ($urandom_range(0, 1) != 0) add_uesc(16'($urandom_range('hD800, 'hDBFF)));
      add_byte(jsu_pkg::CH_BSLASH);
      add_byte(jsu_pkg::CH_U);
      k = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) add_byte((i == k) ? non_hex() : hex_char(4'($urandom)));
    end
  endtask

  task automatic build_line();
    int n;
    line_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'($urandom));
    end else begin
      add_byte(jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) add_token();
      add_byte(jsu_pkg::CH_QUOTE);
      if ($urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, line_q.size());
        while (line_q.size() > n) void'(line_q.pop_back());
      end else if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
    end
  endtask

  // ---- driving ----

  task automatic send_word(input logic [7:0] c, input logic e, input logic typed,
                           input logic [1:0] kd, input logic [2:0] cd);
    int    pause;
    word_t w;
    pause = pick_pause();
    repeat (pause) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    ch       <= c;
    eol      <= e;
    do @(posedge clk); while (in_stall);
    unescape_word(c, e);
    if (typed) begin
      w = '{8'h00, kd, cd, 1'b1};
      pending_out = {pending_out, w};
    end else begin
      pending_out = {pending_out, step_res};
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall || pace == 0) begin
      out_stall  <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall  <= 1'b1;
      stall_left = pick_pause();
    end
  end

  // ---- checking ----

  always @(posedge clk) begin : check_out
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: byte %02h kind %0d code %0d last %0b",
                   out_byte, kind, error_code, last);
      end else begin
        want = pending_out.pop_front();
        if (out_byte !== want.data || kind !== want.kind || error_code !== want.code ||
            last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp byte %02h kind %0d code %0d last %0b, got %02h %0d %0d %0b",
                     want.data, want.kind, want.code, want.last,
                     out_byte, kind, error_code, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      pace = $urandom_range(0, 3);
      send_word(DIRECTED[i].c, DIRECTED[i].e, DIRECTED[i].typed,
                DIRECTED[i].kind, DIRECTED[i].code);
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      build_line();
      pace = $urandom_range(0, 3);
      foreach (line_q[i])
        send_word(line_q[i], i == line_q.size() - 1, 1'b0, jsu_pkg::KIND_BYTE, NO_ERR);
      sent += line_q.size();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
